// ===== rtl/core/paf_pkg.sv =====
// Shared types and constants for the packet allow-list filter.
package paf_pkg;

    typedef logic [15:0] t_key;
    typedef logic [2:0]  t_action;

    localparam t_key KEY_RESET = 16'h0069;

    localparam logic [7:0] TYPE_PING  = 8'd0;
    localparam logic [7:0] TYPE_QUERY = 8'd1;

    localparam t_action ACT_ECHO        = 3'd0;
    localparam t_action ACT_ACCEPT      = 3'd1;
    localparam t_action ACT_UNLISTED    = 3'd2;
    localparam t_action ACT_BAD_TYPE    = 3'd3;
    localparam t_action ACT_BAD_CONTROL = 3'd4;

    typedef struct packed {
        logic [31:0] source_address;
        logic [7:0]  packet_type;
        logic [15:0] control_word;
        logic [31:0] sequence_number;
        logic [7:0]  payload_count;
    } t_in_item;

    typedef struct packed {
        t_action     action;
        logic [31:0] reply_address;
        logic [31:0] reply_sequence;
        logic [7:0]  reply_count;
        logic        newly_listed;
    } t_out_item;

    // Header classification handed from the classifier to the table and top.
    typedef struct packed {
        t_action action;
        logic    learn;
    } t_class;

    // Result of one table lookup.
    typedef struct packed {
        logic listed;
        logic stored;
    } t_lookup;

endpackage

// ===== rtl/core/packet_allowlist_filter.sv =====
// Top level of the packet allow-list filter with learning.
// A header is taken at each rising edge with start high and busy low; busy never rises, so
// one header can be taken in every cycle. The header is registered, checked against the
// control key and the allow-list table in the following cycle, and its result is registered
// in r_out and appears on o_result with o_result_strobe high for exactly one cycle.
// The receiver cannot hold results off. A ping that learns its address updates the table at
// the same edge that registers its result, so the next header already sees the new entry.
// The table is cleared by reset; the control key is written through the
// configuration channel, which is always ready.
module packet_allowlist_filter #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  paf_pkg::t_in_item  i_item,
    output logic               o_result_strobe,
    output paf_pkg::t_out_item o_result,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  paf_pkg::t_key      i_cfg_data
);
    import paf_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in;
    t_key      r_key;
    logic      r_out_valid;
    t_out_item r_out;
    t_out_item n_out;
    t_class    cls;
    t_lookup   lookup;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    // Header decode.
    paf_classify u_classify (
        .i_item   (r_in),
        .i_key    (r_key),
        .i_listed (lookup.listed),
        .o_class  (cls)
    );

    // Allow-list lookup and learning.
    paf_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_learn  (r_in_valid && cls.learn),
        .i_addr   (r_in.source_address),
        .o_lookup (lookup)
    );

    // Result assembly.
    always_comb begin
        n_out.action         = cls.action;
        n_out.reply_address  = r_in.source_address;
        n_out.reply_sequence = r_in.sequence_number;
        n_out.reply_count    = r_in.payload_count;
        n_out.newly_listed   = lookup.stored;
    end

    // Control registers and the key.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_key       <= KEY_RESET;
        end else begin
            r_in_valid  <= start && !busy;
            r_out_valid <= r_in_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_key <= i_cfg_data;
            end
        end
    end

    // Input and result payload registers.
    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_in <= i_item;
        end
        if (r_in_valid) begin
            r_out <= n_out;
        end
    end

    assign o_result_strobe = r_out_valid;
    assign o_result        = r_out;

    // Only an echoed ping can report a newly listed address.
    a_new_is_echo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && o_result.newly_listed) |-> (o_result.action == ACT_ECHO))
        else $error("newly listed flag on a result that is not an echo");

endmodule

// ===== rtl/core/paf_classify.sv =====
// Header classifier: control word check and packet type decode.
module paf_classify (
    input  paf_pkg::t_in_item i_item,
    input  paf_pkg::t_key     i_key,
    input  logic              i_listed,
    output paf_pkg::t_class   o_class
);
    import paf_pkg::*;

    logic ctrl_ok;

    assign ctrl_ok = (i_item.control_word == i_key);

    // The control check takes priority over the type decode.
    // A ping with a good control word is the only header that learns.
    always_comb begin
        o_class.learn = ctrl_ok && (i_item.packet_type == TYPE_PING);
        if (!ctrl_ok) begin
            o_class.action = ACT_BAD_CONTROL;
        end else if (i_item.packet_type == TYPE_PING) begin
            o_class.action = ACT_ECHO;
        end else if (i_item.packet_type == TYPE_QUERY) begin
            o_class.action = i_listed ? ACT_ACCEPT : ACT_UNLISTED;
        end else begin
            o_class.action = ACT_BAD_TYPE;
        end
    end

endmodule

// ===== rtl/core/paf_table.sv =====
// Allow-list table: parallel compare of all entries and first-fit learning.
module paf_table #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_learn,
    input  logic [31:0]      i_addr,
    output paf_pkg::t_lookup o_lookup
);
    import paf_pkg::*;

    logic [31:0]              r_entry [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] w_eq;
    logic [TABLE_ENTRIES-1:0] w_empty;
    logic [TABLE_ENTRIES-1:0] w_first;
    logic [TABLE_ENTRIES:0]   w_seen;
    logic                     w_store;
    logic [TABLE_ENTRIES:0]   w_used_inc;

    // Compare every entry and pick the first one that matches or is empty.
    always_comb begin
        w_seen[0] = 1'b0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            w_eq[i]       = (r_entry[i] == i_addr);
            w_empty[i]    = (r_entry[i] == 32'd0);
            w_first[i]    = (w_eq[i] || w_empty[i]) && !w_seen[i];
            w_seen[i + 1] = w_seen[i] || w_eq[i] || w_empty[i];
        end
    end

    // Store only when the first hit is an empty entry and the address is not zero.
    assign w_store = i_learn && (i_addr != 32'd0) && ((w_first & w_empty) != '0);

    assign o_lookup.listed = (w_eq != '0);
    assign o_lookup.stored = w_store;

    // Table storage, cleared at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                r_entry[i] <= 32'd0;
            end
        end else if (w_store) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                if (w_first[i]) begin
                    r_entry[i] <= i_addr;
                end
            end
        end
    end

    // Used entries plus one; zero in the low bits when the used set is a prefix.
    assign w_used_inc = {1'b0, ~w_empty} + {{TABLE_ENTRIES{1'b0}}, 1'b1};

    // Used entries always form a contiguous run from entry zero.
    a_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_used_inc[TABLE_ENTRIES-1:0] & ~w_empty) == '0)
        else $error("allow-list entries are not filled from entry zero");

    // A store fills exactly one more entry.
    a_store_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_store |=> $countones(~w_empty) == $past($countones(~w_empty)) + 1)
        else $error("store did not fill exactly one entry");

    // An address is never stored twice.
    a_no_dup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_store |-> !o_lookup.listed)
        else $error("stored an address that was already listed");

endmodule
